// ===== rtl/core/kinematic_pose_update_macros.svh =====
// Assertion macros for the kinematic pose update block.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef KINEMATIC_POSE_UPDATE_MACROS_SVH
`define KINEMATIC_POSE_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define KPU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define KPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KPU_ASSERT(lbl, clk, rst, prop, msg)
`define KPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/kpu_pkg.sv =====
// Shared types, constants and the arctangent table for the kinematic pose update.
// Used by the interfaces, the CORDIC and divider units and the top level.
package kpu_pkg;

  localparam int SPEED_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int IWB_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int TRIG_W     = 33;
  localparam int ATAN_N     = 24;
  localparam int IDX_W      = 5;
  localparam int QUO_W      = 20;
  localparam int MUL_A_W    = 37;
  localparam int MUL_B_W    = 31;
  localparam int PROD_W     = 68;
  localparam int STEP_W     = 20;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ANGLE_W-1:0] STEER_LIMIT = 16'sd14564;
  localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
  localparam logic [IWB_W-1:0] IWB_RESET = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEELBASE = 8'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CORD1, S_CORD2, S_MUL_A, S_MUL_R, S_MUL_D,
    S_MUL_X, S_MUL_Y, S_UPD_Y, S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [TRIG_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
    case (i)
      5'd0:  atan_entry = 33'sh020000000;
      5'd1:  atan_entry = 33'sh012E4051E;
      5'd2:  atan_entry = 33'sh009FB385B;
      5'd3:  atan_entry = 33'sh0051111D4;
      5'd4:  atan_entry = 33'sh0028B0D43;
      5'd5:  atan_entry = 33'sh00145D7E1;
      5'd6:  atan_entry = 33'sh000A2F61E;
      5'd7:  atan_entry = 33'sh000517C55;
      5'd8:  atan_entry = 33'sh00028BE53;
      5'd9:  atan_entry = 33'sh000145F2F;
      5'd10: atan_entry = 33'sh0000A2F98;
      5'd11: atan_entry = 33'sh0000517CC;
      5'd12: atan_entry = 33'sh000028BE6;
      5'd13: atan_entry = 33'sh0000145F3;
      5'd14: atan_entry = 33'sh00000A2FA;
      5'd15: atan_entry = 33'sh00000517D;
      5'd16: atan_entry = 33'sh0000028BE;
      5'd17: atan_entry = 33'sh00000145F;
      5'd18: atan_entry = 33'sh000000A30;
      5'd19: atan_entry = 33'sh000000518;
      5'd20: atan_entry = 33'sh00000028C;
      5'd21: atan_entry = 33'sh000000146;
      5'd22: atan_entry = 33'sh0000000A3;
      5'd23: atan_entry = 33'sh000000051;
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/kpu_motion_if.sv =====
// Input channel of the kinematic pose update: speed and angle per transfer.
// Depends on kpu_pkg for the field widths.
interface kpu_motion_if import kpu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SPEED_W-1:0]        speed;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, speed, angle, input ready);
  modport sink (input valid, speed, angle, output ready);
endinterface

// ===== rtl/core/kpu_pose_if.sv =====
// Result channel of the kinematic pose update: the new pose per transfer.
// Depends on kpu_pkg for the field widths.
interface kpu_pose_if import kpu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic [HEAD_W-1:0]       heading;

  modport source (output valid, x_pos, y_pos, heading, input ready);
  modport sink (input valid, x_pos, y_pos, heading, output ready);
endinterface

// ===== rtl/core/kpu_cfg_if.sv =====
// Configuration write channel: register index and write data per transfer.
// Depends on kpu_pkg for the field widths.
interface kpu_cfg_if import kpu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/kpu_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos and sin in Q30.
// Depends on kpu_pkg for widths, the gain and the arctangent table.
module kpu_cordic import kpu_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ANGLE_W-1:0]        angle,
  output logic signed [TRIG_W-1:0]  cos_out,
  output logic signed [TRIG_W-1:0]  sin_out,
  output unit_status_t              status
);

  localparam int ITERS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  logic signed [TRIG_W-1:0] x, y, z;
  logic signed [TRIG_W-1:0] dx, dy, x_next, y_next, z_next;
  logic [IDX_W-1:0]         cnt;
  logic                     flip;
  logic                     flip_in;
  logic [31:0]              z32;
  logic                     last;

  // Angles beyond a quarter turn are turned by a half turn and the result negated.
  assign flip_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign z32     = {angle, 16'b0} ^ {flip_in, 31'b0};
  assign last    = (cnt == IDX_W'(ITERS - 1));

  // One micro-rotation, direction from the sign of the residual angle.
  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    if (!z[TRIG_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - atan_entry(cnt);
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + atan_entry(cnt);
    end
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // Vector, residual angle and results.
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {z32[31], z32};
      flip <= flip_in;
    end else if (status.busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (last) begin
        cos_out <= flip ? -x_next : x_next;
        sin_out <= flip ? -y_next : y_next;
      end
    end
  end

endmodule

// ===== rtl/core/kpu_div.sv =====
// Restoring divider for the steering tangent: (sin << 16) / cos, one quotient bit a cycle.
// Depends on kpu_pkg for widths and the status struct.
module kpu_div import kpu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [TRIG_W-1:0] num,
  input  logic signed [TRIG_W-1:0] den,
  output logic [QUO_W-1:0]         quo_mag,
  output logic                     quo_neg,
  output unit_status_t             status
);

  logic [31:0]              rem;
  logic [31:0]              divisor;
  logic [QUO_W-1:0]         bits;
  logic [IDX_W-1:0]         cnt;
  logic signed [TRIG_W-1:0] num_neg;
  logic [31:0]              mag;
  logic                     den_bad;
  logic [32:0]              trial;
  logic                     fits;

  assign num_neg = -num;
  assign mag     = num[TRIG_W-1] ? num_neg[31:0] : num[31:0];
  assign den_bad = den[TRIG_W-1] || (den == '0);
  assign trial   = {rem, bits[QUO_W-1]};
  assign fits    = (trial >= {1'b0, divisor});

  // Control: a non-positive cosine finishes at once with a zero quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        cnt         <= '0;
        status.busy <= !den_bad;
        status.done <= den_bad;
      end else if (status.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == IDX_W'(QUO_W - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the magnitude quotient is built from the top bit down.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= {4'b0, mag[31:4]};
      bits    <= {mag[3:0], 16'b0};
      divisor <= den[31:0];
      quo_mag <= '0;
      quo_neg <= num[TRIG_W-1] && !den_bad;
    end else if (status.busy) begin
      rem     <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      bits    <= {bits[QUO_W-2:0], 1'b0};
      quo_mag <= {quo_mag[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/kinematic_pose_update.sv =====
// Kinematic pose update: keeps x, y and heading and returns the new pose for every input.
// Depends on kpu_pkg, the channel interfaces, kpu_cordic, kpu_div and the assertion macros.
//
// One input item is taken at a time; the block is not ready again until the item's pose
// has been computed, though a finished pose may still wait on the result channel. The
// work is done by the iterative CORDIC, one micro-rotation a cycle, followed in bicycle
// mode by the tangent divider running beside a second CORDIC pass on the heading, and
// then by five passes through one shared multiplier (in particle mode, only the passes
// for x and y). Configuration writes are always taken and should only be made while the
// block is idle.
`include "kinematic_pose_update_macros.svh"
module kinematic_pose_update import kpu_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input logic            clk,
  input logic            rst,
  kpu_cfg_if.sink        cfg,
  kpu_motion_if.sink     motion,
  kpu_pose_if.source     pose
);

  state_t state, state_next;

  logic                      model_mode;
  logic [IWB_W-1:0]          inv_wheelbase;
  logic [SPEED_W-1:0]        speed;
  logic [ANGLE_W-1:0]        angle;
  logic signed [POS_W-1:0]   pose_x, pose_y;
  logic [HEAD_W-1:0]         pose_heading;
  logic signed [POS_W-1:0]   out_x, out_y;
  logic [HEAD_W-1:0]         out_heading;
  logic                      out_valid;

  logic                      cord_start, div_start;
  logic [ANGLE_W-1:0]        cord_angle, in_angle;
  logic signed [TRIG_W-1:0]  cos_val, sin_val;
  unit_status_t              cord_stat, div_stat;
  logic [QUO_W-1:0]          tan_mag;
  logic                      tan_neg;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [49:0]               step_sum;
  logic signed [STEP_W-1:0]  step;
  logic signed [POS_W+1:0]   sum_x, sum_y;
  logic signed [POS_W-1:0]   sat_x, sat_y;
  logic [HEAD_W-1:0]         head_delta;

  kpu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_angle),
    .cos_out(cos_val), .sin_out(sin_val), .status(cord_stat)
  );

  kpu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sin_val), .den(cos_val),
    .quo_mag(tan_mag), .quo_neg(tan_neg), .status(div_stat)
  );

  // Channel handshakes.
  assign cfg.ready     = 1'b1;
  assign motion.ready  = (state == S_IDLE);
  assign pose.valid    = out_valid;
  assign pose.x_pos    = out_x;
  assign pose.y_pos    = out_y;
  assign pose.heading  = out_heading;

  // Steering clamp in bicycle mode.
  always_comb begin
    in_angle = motion.angle;
    if (model_mode) begin
      if (motion.angle > STEER_LIMIT) begin
        in_angle = STEER_LIMIT;
      end else if (motion.angle < -STEER_LIMIT) begin
        in_angle = -STEER_LIMIT;
      end
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A: begin
        mul_a = MUL_A_W'(tan_mag);
        mul_b = MUL_B_W'(speed);
      end
      S_MUL_R: begin
        mul_a = {1'b0, prod[35:0]};
        mul_b = MUL_B_W'(inv_wheelbase);
      end
      S_MUL_D: begin
        mul_a = {9'b0, prod[51:24]};
        mul_b = {1'b0, RAD_TO_BAM};
      end
      S_MUL_X: begin
        mul_a = MUL_A_W'(cos_val);
        mul_b = MUL_B_W'(speed);
      end
      S_MUL_Y: begin
        mul_a = MUL_A_W'(sin_val);
        mul_b = MUL_B_W'(speed);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Rounded position step and saturating accumulation.
  always_comb begin
    step_sum   = prod[49:0] + 50'(1 << 29);
    step       = step_sum[49:30];
    sum_x      = {{2{pose_x[POS_W-1]}}, pose_x} + (POS_W+2)'(step);
    sum_y      = {{2{pose_y[POS_W-1]}}, pose_y} + (POS_W+2)'(step);
    sat_x      = sum_x[POS_W-1:0];
    sat_y      = sum_y[POS_W-1:0];
    head_delta = prod[47:32];
    if (sum_x[POS_W+1:POS_W-1] != '0 && sum_x[POS_W+1:POS_W-1] != '1) begin
      sat_x = sum_x[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    if (sum_y[POS_W+1:POS_W-1] != '0 && sum_y[POS_W+1:POS_W-1] != '1) begin
      sat_y = sum_y[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and unit starts.
  always_comb begin
    state_next = state;
    cord_start = 1'b0;
    div_start  = 1'b0;
    cord_angle = pose_heading;
    case (state)
      S_IDLE: begin
        cord_angle = in_angle;
        if (motion.valid) begin
          cord_start = 1'b1;
          state_next = S_CORD1;
        end
      end
      S_CORD1: begin
        if (cord_stat.done) begin
          if (model_mode) begin
            cord_start = 1'b1;
            div_start  = 1'b1;
            state_next = S_CORD2;
          end else begin
            state_next = S_MUL_X;
          end
        end
      end
      S_CORD2: begin
        if (!cord_stat.busy && !div_stat.busy) begin
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: state_next = S_MUL_R;
      S_MUL_R: state_next = S_MUL_D;
      S_MUL_D: state_next = S_MUL_X;
      S_MUL_X: state_next = S_MUL_Y;
      S_MUL_Y: state_next = S_UPD_Y;
      S_UPD_Y: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || pose.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_mode    <= 1'b1;
      inv_wheelbase <= IWB_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MODEL_MODE) begin
        model_mode <= cfg.data[0];
      end else if (cfg.index == CFG_INV_WHEELBASE) begin
        inv_wheelbase <= cfg.data;
      end
    end
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (motion.valid && motion.ready) begin
      speed <= motion.speed;
      angle <= in_angle;
    end
  end

  // Pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (state == S_CORD1 && cord_stat.done && !model_mode) begin
        pose_heading <= pose_heading + angle;
      end
      if (state == S_MUL_X && model_mode) begin
        pose_heading <= tan_neg ? pose_heading - head_delta : pose_heading + head_delta;
      end
      if (state == S_MUL_Y) begin
        pose_x <= sat_x;
      end
      if (state == S_UPD_Y) begin
        pose_y <= sat_y;
      end
    end
  end

  // Result register, loaded once the result channel is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || pose.ready)) begin
      out_valid <= 1'b1;
    end else if (pose.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || pose.ready)) begin
      out_x       <= pose_x;
      out_y       <= pose_y;
      out_heading <= pose_heading;
    end
  end

  `KPU_ASSERT_NEXT(a_accept_starts_cordic, clk, rst, motion.valid && motion.ready, state == S_CORD1 && cord_stat.busy, "accepted item did not start the CORDIC")
  `KPU_ASSERT(a_cordic_no_restart, clk, rst, cord_start |-> !cord_stat.busy, "CORDIC restarted while busy")
  `KPU_ASSERT_NEXT(a_result_loaded, clk, rst, state == S_OUT && (!out_valid || pose.ready), out_valid && state == S_IDLE, "finished pose not presented")

endmodule
